// File: design/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rbia_pkg.sv
// Package for the ring buffer with indexed access: shared widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbia_pkg;

	localparam int SIZE_W = 13;   // ring size register and transfer count
	localparam int IDX_W  = 32;   // signed start index
	localparam int DATA_W = 8;    // one byte of the ring

	typedef logic [SIZE_W-1:0] size_t;

endpackage

`default_nettype wire

// File: design/rbia_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rbia_mod.sv
// Iterative signed modulo unit: reduces the start index into [0, size-1].
// Depends on rbia_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module rbia_mod (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [rbia_pkg::IDX_W-1:0] index,
	input  wire rbia_pkg::size_t                   size,
	output logic                                   done,
	output rbia_pkg::size_t                        result
);
	import rbia_pkg::*;

	localparam int BITS_PER_STEP = 4;
	localparam int STEPS = IDX_W / BITS_PER_STEP;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] dividend_q;
	size_t            rem_q;
	size_t            rem_next;
	logic [IDX_W-1:0] magnitude;

	assign magnitude = index[IDX_W-1] ? (~index + 1'b1) : index;

	// Restoring remainder, four dividend bits per cycle.
	always_comb begin
		logic [SIZE_W:0] t;
		size_t r;
		r = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, dividend_q[IDX_W-1-i]};
			if (t >= {1'b0, size}) begin
				t = t - {1'b0, size};
			end
			r = t[SIZE_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			rem_q      <= '0;
			dividend_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				cnt_q      <= '0;
				neg_q      <= index[IDX_W-1];
				rem_q      <= '0;
				dividend_q <= magnitude;
			end else if (busy_q) begin
				rem_q      <= rem_next;
				dividend_q <= dividend_q << BITS_PER_STEP;
				cnt_q      <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A negative index counts back from the end of the ring.
	assign result = (neg_q && rem_q != '0) ? size - rem_q : rem_q;
	assign done   = done_q;

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_mod_start_busy, clk, arst_n, start, busy_q, "modulo unit did not start")
	`ASSERT_NEXT(a_mod_done_pulse, clk, arst_n, done_q, !done_q && !busy_q,
		"done is not a single pulse")

endmodule

`default_nettype wire

// File: design/ring_buffer_indexed_access.sv
// Top level of the ring buffer with indexed access: control, ring RAM, modulo unit.
// Depends on rbia_pkg, rbia_ram, rbia_mod and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// A byte ring of up to MAX_DEPTH entries, accessed in transfers. Each input request is one
// byte of a read (op = 0) or write (op = 1) transfer; a request with first = 1 starts a new
// transfer at its signed start index, reduced modulo the configured ring size so that negative
// indices count back from the end. Later bytes take consecutive addresses that wrap at the ring
// size, and a transfer is clamped at ring-size bytes: bytes beyond that come back with
// accepted = 0 and do not touch the ring. Every input request gives exactly one result request
// with the read byte (zero for writes and dropped bytes), the accepted flag and the number of
// bytes accepted so far in the transfer. Reading an entry that was never written returns an
// undefined byte. The ring size register (0 acts as 1, values above MAX_DEPTH act as MAX_DEPTH)
// is written through cfg_we / cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. Requests are handled one at a time: a write or dropped byte
// passes through the access state; a read also passes a read state for the registered read
// of the single-port ring RAM. A first byte waits for the modulo unit, which reduces the 32-bit
// index four bits per cycle. Results sit in an output register, so input goes on while one waits.

module ring_buffer_indexed_access #(
	parameter int MAX_DEPTH = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration: ring size.
	input  wire logic                         cfg_we,
	input  wire rbia_pkg::size_t              cfg_data,
	// Input requests.
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [39:0]                  s_tdata,   // start_index[31:0], write_data[39:32]
	input  wire logic [1:0]                   s_tuser,   // op[0], first[1]
	// Result requests.
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [23:0]                       m_tdata,   // read_data[7:0], transfer_count[20:8]
	output logic                              m_tuser    // accepted[0]
);
	import rbia_pkg::*;

	localparam int AW = $clog2(MAX_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_ACC,
		S_RD
	} state_t;

	state_t              state_q;
	size_t               ring_size_q;
	logic [AW-1:0]       next_addr_q;
	size_t               count_q;
	logic                op_q;
	logic [DATA_W-1:0]   wdata_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_rdata_q;
	logic                out_acc_q;
	size_t               out_count_q;

	size_t               eff_size;
	logic [AW-1:0]       addr_cur;
	logic [AW:0]         addr_inc;
	logic [AW-1:0]       addr_nxt;
	logic                acc;
	logic                slot_free;
	logic                out_load;
	logic                in_fire;
	logic                mod_start;
	logic                mod_done;
	size_t               mod_result;
	logic                ram_en;
	logic                ram_we;
	logic [DATA_W-1:0]   ram_rdata;

	// Effective ring size after clamping the register value.
	always_comb begin
		if (ring_size_q == '0) begin
			eff_size = size_t'(1);
		end else if (32'(ring_size_q) > MAX_DEPTH) begin
			eff_size = SIZE_W'(MAX_DEPTH);
		end else begin
			eff_size = ring_size_q;
		end
	end

	// The size may have shrunk since the address was computed; fall back to entry zero.
	assign addr_cur  = (32'(next_addr_q) >= 32'(eff_size)) ? '0 : next_addr_q;
	assign addr_inc  = {1'b0, addr_cur} + 1'b1;
	assign addr_nxt  = (32'(addr_inc) >= 32'(eff_size)) ? '0 : addr_inc[AW-1:0];
	assign acc       = count_q < eff_size;

	assign slot_free = !out_valid_q || m_tready;
	// A result becomes valid from the access state, or from the read state that follows it for an accepted read.
	assign out_load  = ((state_q == S_ACC) && slot_free && !(acc && !op_q)) || (state_q == S_RD);
	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign mod_start = in_fire && s_tuser[1];

	assign ram_en    = (state_q == S_ACC) && slot_free && acc;
	assign ram_we    = op_q;

	rbia_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (addr_cur),
		.wdata(wdata_q),
		.rdata(ram_rdata)
	);

	rbia_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.index (s_tdata[IDX_W-1:0]),
		.size  (eff_size),
		.done  (mod_done),
		.result(mod_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_size_q <= SIZE_W'(MAX_DEPTH);
			next_addr_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_rdata_q <= '0;
			out_acc_q   <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (cfg_we) begin
				ring_size_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= s_tuser[1] ? S_DIV : S_ACC;
					end
				end
				S_DIV: begin
					// Start of a new transfer: load the reduced index, clear the count.
					if (mod_done) begin
						next_addr_q <= AW'(mod_result);
						count_q     <= '0;
						state_q     <= S_ACC;
					end
				end
				S_ACC: begin
					if (slot_free) begin
						out_rdata_q <= '0;
						out_acc_q   <= acc;
						out_count_q <= acc ? count_q + 1'b1 : count_q;
						if (acc) begin
							next_addr_q <= addr_nxt;
							count_q     <= count_q + 1'b1;
						end
						if (acc && !op_q) begin
							// Wait for the registered RAM read.
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD: begin
					out_rdata_q <= ram_rdata;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latched request fields.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= s_tuser[0];
			wdata_q <= s_tdata[IDX_W +: DATA_W];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_rdata_q};
	assign m_tuser  = out_acc_q;

	`include "assert_macros.svh"

	`ASSERT_IMPLY(a_rd_slot_free, clk, arst_n, state_q == S_RD, !out_valid_q,
		"read data lands on a full output register")
	`ASSERT_ALWAYS(a_addr_range, clk, arst_n, 32'(next_addr_q) < MAX_DEPTH,
		"ring address out of range")
	`ASSERT_IMPLY(a_mod_done_state, clk, arst_n, mod_done, state_q == S_DIV,
		"modulo result outside of start phase")

endmodule

`default_nettype wire
